// File: design/assert_macros.svh
// Assertion helpers for the design folder.
// In synthesis the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check sampled on the rising clock edge and held off during reset.
`define CDQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("circular_deque assertion failed");
// Concurrent check that also holds while reset is asserted.
`define CDQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("circular_deque assertion failed");
`else
`define CDQ_ASSERT(label, clk, rst, prop)
`define CDQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: design/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

   // Request commands.
   typedef enum logic [1:0] {
      CDQ_PUSH_FRONT = 2'd0,
      CDQ_PUSH_REAR  = 2'd1,
      CDQ_POP_FRONT  = 2'd2,
      CDQ_POP_REAR   = 2'd3
   } cdq_cmd_type;

   // Response status codes.
   typedef enum logic [1:0] {
      CDQ_DONE       = 2'd0,
      CDQ_PUSH_FULL  = 2'd1,
      CDQ_POP_EMPTY  = 2'd2
   } cdq_status_type;

   // Control sequencer states.
   typedef enum logic {
      CDQ_ST_IDLE = 1'b0,
      CDQ_ST_READ = 1'b1
   } cdq_state_type;

   typedef struct packed {
      cdq_cmd_type        command;
      logic signed [31:0] value;
   } cdq_req_type;

   typedef struct packed {
      cdq_status_type     status;
      logic signed [31:0] front_value;
      logic signed [31:0] rear_value;
      logic               is_empty;
      logic               is_full;
   } cdq_rsp_type;

endpackage

`default_nettype wire

// File: design/circular_deque.sv
// circular_deque: a double-ended queue of up to DEPTH signed words kept in a
// ring store. Each request carries a command (push front, push rear, pop
// front, pop rear) and a value for the pushes, and produces exactly one
// response with a status, the front and rear words after the step (the most
// negative word when the deque is empty), and the empty and full flags. A
// push into a full deque or a pop from an empty one leaves the contents
// untouched and reports an error status. Each request passes through the
// IDLE state, in which it is accepted, the indices are updated, the store is
// written and the new head and tail entries are read, and then the READ
// state, which takes the store's registered read data and loads the
// response into the output register. A response waiting in that register
// does not stop the next request being accepted. A stall on the response
// side delays the loading of the following response, and req_stall stays
// high until that load, so the request after it waits as well. No clearing
// pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module circular_deque #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire cdq_pkg::cdq_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output cdq_pkg::cdq_rsp_type      rsp_payload
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [DATA_WIDTH-1:0] WORD_MIN = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

   // Sign-extend a stored word and keep the 32 bits of the response field.
   function automatic logic [31:0] word_out(input logic [DATA_WIDTH-1:0] w);
      logic signed [63:0] ext;
      ext = 64'($signed(w));
      return ext[31:0];
   endfunction

   // Sequencer and deque state.
   cdq_pkg::cdq_state_type  state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic                    empty_ff, empty_in;

   // Per-request context carried into the read cycle.
   cdq_pkg::cdq_status_type status_ff, status_in;
   logic                    fwd_head_ff, fwd_head_in;
   logic                    fwd_tail_ff, fwd_tail_in;
   logic [DATA_WIDTH-1:0]   fwd_data_ff;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   cdq_pkg::cdq_rsp_type    rsp_payload_ff, rsp_payload_in;

   // Store access.
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic                    rd_en;
   logic [DATA_WIDTH-1:0]   rd_head_data;
   logic [DATA_WIDTH-1:0]   rd_tail_data;

   logic                    req_accept;
   logic                    rsp_load;
   logic                    full_now;
   logic [IDX_W-1:0]        head_next, head_prev, tail_next, tail_prev;
   logic [DATA_WIDTH-1:0]   front_word, rear_word;

   cdq_ring_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (head_in),
      .rd_addr_b (tail_in),
      .rd_data_a (rd_head_data),
      .rd_data_b (rd_tail_data)
   );

   // Ring index steps, wrapping at DEPTH whether or not it is a power of two.
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   // Full means one more step past the tail would land on the head.
   assign full_now = !empty_ff && (tail_next == head_ff);

   assign req_stall  = (state_ff != cdq_pkg::CDQ_ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // The response register may be loaded when empty or being emptied now.
   assign rsp_load = (state_ff == cdq_pkg::CDQ_ST_READ) && (!rsp_valid_ff || !rsp_stall);

   // A word written in the same cycle as its read is taken from the
   // forwarding register instead of the store's stale read data.
   assign front_word = fwd_head_ff ? fwd_data_ff : rd_head_data;
   assign rear_word  = fwd_tail_ff ? fwd_data_ff : rd_tail_data;

   assign wr_data = DATA_WIDTH'(req_payload.value);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      empty_in       = empty_ff;
      status_in      = status_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      rd_en          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      unique case (state_ff)
         cdq_pkg::CDQ_ST_IDLE: begin
            if (req_accept) begin
               status_in = cdq_pkg::CDQ_DONE;
               rd_en     = 1'b1;
               state_in  = cdq_pkg::CDQ_ST_READ;
               unique case (req_payload.command) inside
                  cdq_pkg::CDQ_PUSH_FRONT, cdq_pkg::CDQ_PUSH_REAR: begin
                     if (full_now) begin
                        status_in = cdq_pkg::CDQ_PUSH_FULL;
                     end else if (empty_ff) begin
                        // The first word always lands in entry zero.
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        head_in  = '0;
                        tail_in  = '0;
                        empty_in = 1'b0;
                     end else if (req_payload.command == cdq_pkg::CDQ_PUSH_FRONT) begin
                        wr_en   = 1'b1;
                        wr_addr = head_prev;
                        head_in = head_prev;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = tail_next;
                        tail_in = tail_next;
                     end
                  end
                  cdq_pkg::CDQ_POP_FRONT, cdq_pkg::CDQ_POP_REAR: begin
                     if (empty_ff) begin
                        status_in = cdq_pkg::CDQ_POP_EMPTY;
                     end else if (head_ff == tail_ff) begin
                        // Removing the last word returns both indices to zero.
                        empty_in = 1'b1;
                        head_in  = '0;
                        tail_in  = '0;
                     end else if (req_payload.command == cdq_pkg::CDQ_POP_FRONT) begin
                        head_in = head_next;
                     end else begin
                        tail_in = tail_prev;
                     end
                  end
               endcase
            end
         end
         cdq_pkg::CDQ_ST_READ: begin
            if (rsp_load) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.status      = status_ff;
               rsp_payload_in.is_empty    = empty_ff;
               rsp_payload_in.is_full     = full_now;
               rsp_payload_in.front_value = empty_ff ? word_out(WORD_MIN)
                                                     : word_out(front_word);
               rsp_payload_in.rear_value  = empty_ff ? word_out(WORD_MIN)
                                                     : word_out(rear_word);
               state_in                   = cdq_pkg::CDQ_ST_IDLE;
            end
         end
      endcase
   end

   assign fwd_head_in = wr_en && (wr_addr == head_in);
   assign fwd_tail_in = wr_en && (wr_addr == tail_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::CDQ_ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         status_ff    <= cdq_pkg::CDQ_DONE;
         fwd_head_ff  <= 1'b0;
         fwd_tail_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         if (req_accept) begin
            fwd_head_ff <= fwd_head_in;
            fwd_tail_ff <= fwd_tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (wr_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // An empty deque always has both indices parked at zero.
   `CDQ_ASSERT(a_empty_parks_idx, clock, reset, empty_ff |-> (head_ff == '0 && tail_ff == '0))
   // The indices never leave the ring.
   `CDQ_ASSERT(a_idx_in_range, clock, reset, (head_ff <= LAST_IDX && tail_ff <= LAST_IDX))
   // An accepted request is always followed by its read cycle.
   `CDQ_ASSERT(a_accept_to_read, clock, reset, req_accept |=> (state_ff == cdq_pkg::CDQ_ST_READ))
   // Loading the output register always presents a response next cycle.
   `CDQ_ASSERT(a_load_presents, clock, reset, rsp_load |=> (rsp_valid && !req_stall))
   // The store is never written outside an accepted request.
   `CDQ_ASSERT_ALWAYS(a_write_needs_accept, clock, wr_en |-> req_accept)

endmodule

`default_nettype wire

// File: design/cdq_ring_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Ring store: one write port and two read ports, read data registered.
module cdq_ring_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [DATA_WIDTH-1:0]         wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr_b,
   output logic      [DATA_WIDTH-1:0]         rd_data_a,
   output logic      [DATA_WIDTH-1:0]         rd_data_b
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Reads return the contents before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/circular_deque_tb.sv
`timescale 1ns / 1ps

module circular_deque_tb;
   import cdq_pkg::*;

   // The block is built at its default size, and the shadow copy below
   // follows the same numbers.
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   // Value reported for an empty peek: the most negative word.
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

   // Only the first few faults are printed in full; the rest are counted.
   localparam int SHOWN_FAULTS = 10;

   // Cycles to wait for stray responses once everything has drained.
   localparam int SETTLE_CYCLES = 8;

   // The receiver changes between these stall patterns from time to time.
   typedef enum logic [1:0] {
      STALL_NONE     = 2'd0,
      STALL_LIGHT    = 2'd1,
      STALL_HEAVY    = 2'd2,
      STALL_PERIODIC = 2'd3
   } stall_mode_type;

   // One queued request, with a flag asking the sender to hold it back until
   // every response so far has arrived.
   typedef struct {
      cdq_req_type req;
      bit          wait_drain;
   } backlog_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cdq_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cdq_rsp_type rsp_payload;

   // Requests still to be sent, and responses predicted but not yet seen.
   backlog_entry_type cmd_backlog[$];
   cdq_rsp_type       awaited_rsp[$];

   // Shadow copy of the deque contents.
   logic signed [31:0] shadow_ring[DEPTH];
   int                 shadow_head  = 0;
   int                 shadow_tail  = 0;
   bit                 shadow_empty = 1'b1;

   int fault_count = 0;

   // Set at each rising edge when the request on the port was taken.
   bit req_taken = 1'b0;

   // Sender burst state.
   int burst_left = 1;
   int gap_left   = 0;

   // Receiver stall state.
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             stall_phase = 0;

   circular_deque #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic int ring_next(int i);
      return (i == DEPTH - 1) ? 0 : i + 1;
   endfunction

   function automatic int ring_prev(int i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   function automatic bit shadow_full();
      return !shadow_empty && ring_next(shadow_tail) == shadow_head;
   endfunction

   // Applies one request to the shadow deque and returns the response that
   // the block ought to give for it.
   function automatic cdq_rsp_type apply_deque_cmd(cdq_req_type r);
      cdq_rsp_type o;
      int          slot;
      o        = '0;
      o.status = CDQ_DONE;
      case (r.command)
         CDQ_PUSH_FRONT, CDQ_PUSH_REAR: begin
            if (shadow_full()) begin
               o.status = CDQ_PUSH_FULL;
            end else begin
               // A push into an empty deque always lands in entry zero,
               // whichever end it names.
               if (shadow_empty) begin
                  shadow_head  = 0;
                  shadow_tail  = 0;
                  shadow_empty = 1'b0;
                  slot         = 0;
               end else if (r.command == CDQ_PUSH_FRONT) begin
                  shadow_head = ring_prev(shadow_head);
                  slot        = shadow_head;
               end else begin
                  shadow_tail = ring_next(shadow_tail);
                  slot        = shadow_tail;
               end
               shadow_ring[slot] = r.value;
            end
         end
         default: begin
            if (shadow_empty) begin
               o.status = CDQ_POP_EMPTY;
            end else if (shadow_head == shadow_tail) begin
               // Popping the last word sends both indices home.
               shadow_empty = 1'b1;
               shadow_head  = 0;
               shadow_tail  = 0;
            end else if (r.command == CDQ_POP_FRONT) begin
               shadow_head = ring_next(shadow_head);
            end else begin
               shadow_tail = ring_prev(shadow_tail);
            end
         end
      endcase
      if (shadow_empty) begin
         o.front_value = WORD_MIN;
         o.rear_value  = WORD_MIN;
      end else begin
         o.front_value = shadow_ring[shadow_head];
         o.rear_value  = shadow_ring[shadow_tail];
      end
      o.is_empty = shadow_empty;
      o.is_full  = shadow_full();
      return o;
   endfunction

   task automatic note_fault(string what);
      fault_count = fault_count + 1;
      if (fault_count <= SHOWN_FAULTS) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   task automatic queue_cmd(cdq_cmd_type cmd, logic signed [31:0] value, bit hold);
      backlog_entry_type e;
      e.req.command = cmd;
      e.req.value   = value;
      e.wait_drain  = hold;
      cmd_backlog.push_back(e);
   endtask

   // Mostly ordinary words, with the extremes and the all-zero and all-one
   // patterns turning up often enough to matter.
   function automatic logic signed [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         return WORD_MAX;
      end else if (roll < 16) begin
         return WORD_MIN;
      end else if (roll < 20) begin
         return 32'sd0;
      end else if (roll < 24) begin
         return -32'sd1;
      end
      return $urandom;
   endfunction

   // Sender. A request is presented at the falling edge and held until a
   // rising edge takes it; gaps are only inserted between requests, so a
   // presented request never changes while it is stalled.
   always @(negedge clock) begin : drive_proc
      logic              next_valid;
      cdq_req_type       next_payload;
      backlog_entry_type next_entry;
      next_valid   = req_valid;
      next_payload = req_payload;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_taken) begin
            next_valid = 1'b0;
         end
         if (!next_valid && cmd_backlog.size() != 0) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
            end else if (!cmd_backlog[0].wait_drain || awaited_rsp.size() == 0) begin
               next_entry   = cmd_backlog.pop_front();
               next_valid   = 1'b1;
               next_payload = next_entry.req;
               if (burst_left <= 1) begin
                  // End of a burst: choose the next burst and the pause
                  // before it. About a third of pauses are empty, so long
                  // stretches run back to back.
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left = burst_left - 1;
               end
            end
         end
      end
      req_valid   <= next_valid;
      req_payload <= next_payload;
   end

   // Receiver. The stall pattern is chosen anew at random whenever its run ends,
   // so that stalls land on every phase of the request pipeline.
   always @(negedge clock) begin : stall_proc
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left = mode_left - 1;
         end
         stall_phase = (stall_phase + 1) % 5;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 99) < 30);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 99) < 80);
            end
            default: begin
               rsp_stall <= (stall_phase < 2);
            end
         endcase
      end
   end

   // Monitor. At each rising edge the response side is checked first, then
   // any request taken at the same edge is predicted. A response can never
   // belong to a request taken at the same edge, so the order is safe.
   always @(posedge clock) begin : watch_proc
      cdq_rsp_type want;
      bit          bad;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               note_fault($sformatf("response with none outstanding: %p", rsp_payload));
            end else begin
               want = awaited_rsp.pop_front();
               bad  = (rsp_payload.status      !== want.status)
                   || (rsp_payload.front_value !== want.front_value)
                   || (rsp_payload.rear_value  !== want.rear_value)
                   || (rsp_payload.is_empty    !== want.is_empty)
                   || (rsp_payload.is_full     !== want.is_full);
               if (bad) begin
                  note_fault($sformatf(
                     "expected st=%0d front=%h rear=%h empty=%b full=%b, got st=%0d front=%h rear=%h empty=%b full=%b",
                     want.status, want.front_value, want.rear_value, want.is_empty,
                     want.is_full, rsp_payload.status, rsp_payload.front_value,
                     rsp_payload.rear_value, rsp_payload.is_empty, rsp_payload.is_full));
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            awaited_rsp.push_back(apply_deque_cmd(req_payload));
         end
      end
   end

   // Stimulus and end of run.
   initial begin : main_proc
      int      i;
      int      phase_left;
      int      push_pct;
      bit      is_push;
      bit      hold;
      // Directed part. Both pops on an empty deque are rejected first.
      queue_cmd(CDQ_POP_FRONT, 32'sd0, 1'b0);
      queue_cmd(CDQ_POP_REAR, WORD_MAX, 1'b0);
      // The extremes go in at either end, then come out again, the second
      // pop taking the last word.
      queue_cmd(CDQ_PUSH_FRONT, WORD_MAX, 1'b0);
      queue_cmd(CDQ_PUSH_REAR, WORD_MIN, 1'b0);
      queue_cmd(CDQ_POP_FRONT, -32'sd1, 1'b0);
      queue_cmd(CDQ_POP_REAR, 32'sd0, 1'b0);
      // Fill the deque from both ends, so the head wraps below zero, and
      // then try one more push at each end against a full deque.
      for (i = 0; i < DEPTH; i++) begin
         queue_cmd((i % 2 == 0) ? CDQ_PUSH_REAR : CDQ_PUSH_FRONT,
                   (i % 4 == 0) ? -32'sd1 : pick_value(), 1'b0);
      end
      queue_cmd(CDQ_PUSH_FRONT, WORD_MIN, 1'b0);
      queue_cmd(CDQ_PUSH_REAR, WORD_MAX, 1'b0);

      // Random part. Phases lean towards pushing, towards popping or
      // neither, so the deque keeps swinging between empty and full and
      // the indices wrap at both ends many times over.
      phase_left = 0;
      push_pct   = 50;
      for (i = 0; i < 1150; i++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         phase_left = phase_left - 1;
         is_push    = ($urandom_range(0, 99) < push_pct);
         // Twice in the run the sender holds a request back until the
         // block has fully drained.
         hold = (i == 400) || (i == 800);
         if (is_push) begin
            queue_cmd($urandom_range(0, 1) ? CDQ_PUSH_REAR : CDQ_PUSH_FRONT,
                      pick_value(), hold);
         end else begin
            queue_cmd($urandom_range(0, 1) ? CDQ_POP_REAR : CDQ_POP_FRONT,
                      $urandom, hold);
         end
      end

      // Reset is released at a falling clock edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to go out and every response to come back,
      // then wait out the settle time to catch anything unasked for.
      while (cmd_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         note_fault($sformatf("%0d responses never arrived", awaited_rsp.size()));
      end

      if (fault_count == 0) begin
         $display("PASS circular_deque");
      end else begin
         $display("FAIL circular_deque");
      end
      $finish;
   end

   // Watchdog: fails the run if it has not finished.
   initial begin : watchdog_proc
      #2_000_000;
      $display("FAIL circular_deque");
      $finish;
   end

endmodule

// File: circular_deque.f
+incdir+design
design/cdq_pkg.sv
design/cdq_ring_mem.sv
design/circular_deque.sv
tb/sv/circular_deque_tb.sv
